// ----- hw/rtl/binary_image_boundary_pixel_count_core_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the boundary pixel counter
// Concurrent checks on clk with synchronous reset rst, empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef BINARY_IMAGE_BOUNDARY_PIXEL_COUNT_CORE_MACROS_SVH
`define BINARY_IMAGE_BOUNDARY_PIXEL_COUNT_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define BIBPC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define BIBPC_ASSERT_NEVER(label, expr, msg) \
  `BIBPC_ASSERT(label, !(expr), msg)
`else
`define BIBPC_ASSERT(label, prop, msg)
`define BIBPC_ASSERT_NEVER(label, expr, msg)
`endif

`endif

// ----- hw/rtl/bibpc_pkg.sv -----
// ----------------------------------------------------------------------------
// bibpc_pkg
// Shared types and constants of the boundary pixel counter.
// ----------------------------------------------------------------------------
package bibpc_pkg;

  localparam int CFG_W       = 11;
  localparam int CFG_INDEX_W = 1;
  localparam int COUNT_W     = 21;
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
  localparam logic [CFG_W-1:0] DIM_RESET = 11'd1024;

  localparam int OUT_DEPTH = 4;
  localparam int OUT_PTR_W = 2;
  localparam int OUT_CNT_W = 3;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } reg_index_t;

  // one line store entry: land bit and boundary already known
  typedef struct packed {
    logic boundary;
    logic land;
  } cell_t;

  typedef struct packed {
    logic [COUNT_W-1:0] boundary_count;
    logic               frame_done;
  } result_t;

endpackage

// ----- hw/rtl/bibpc_pixel_if.sv -----
// ----------------------------------------------------------------------------
// bibpc_pixel_if
// Pixel input channel: one binary pixel per item.
// ----------------------------------------------------------------------------
interface bibpc_pixel_if;
  logic valid;
  logic ready;
  logic is_land;

  modport source (output valid, output is_land, input ready);
  modport sink (input valid, input is_land, output ready);
endinterface

// ----- hw/rtl/bibpc_result_if.sv -----
// ----------------------------------------------------------------------------
// bibpc_result_if
// Result channel: running boundary count and frame end flag per item.
// ----------------------------------------------------------------------------
interface bibpc_result_if import bibpc_pkg::*;;
  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] boundary_count;
  logic               frame_done;

  modport source (output valid, output boundary_count, output frame_done, input ready);
  modport sink (input valid, input boundary_count, input frame_done, output ready);
endinterface

// ----- hw/rtl/bibpc_line_ram.sv -----
// ----------------------------------------------------------------------------
// bibpc_line_ram
// One-row line store, one write and one registered read port.
// ----------------------------------------------------------------------------
module bibpc_line_ram import bibpc_pkg::*; #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  cell_t         wdata,
  input  logic [AW-1:0] raddr,
  output cell_t         rdata
);

  cell_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/binary_image_boundary_pixel_count_core.sv -----
// ----------------------------------------------------------------------------
// binary_image_boundary_pixel_count_core
// Counts land pixels on the image border or next to water, raster order.
// ----------------------------------------------------------------------------
// Takes one pixel per clock while the output queue has room, with no gaps
// between rows or frames. Each accepted pixel returns one item carrying the
// running count of boundary land pixels of the current frame; the frame's
// last pixel sets frame_done and the count restarts with the next pixel. A
// pixel is decided when the pixel below it arrives, through a one-row line
// store in a single-port-write RAM with a registered read; the row's last
// entry waits for a free port, and reads forward any write of the same cycle.
// A four-item output queue lets the input run while results wait to be taken.
// image_width and image_height may be written only while idle; a position at
// or past a smaller new size is taken as the last column or row.
// ----------------------------------------------------------------------------
`include "binary_image_boundary_pixel_count_core_macros.svh"

module binary_image_boundary_pixel_count_core import bibpc_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                   clk,
  input  logic                   rst,
  bibpc_pixel_if.sink            pixel_in,
  bibpc_result_if.source         result_out,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]       cfg_data
);

  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int XW = CW + 1;
  localparam int YW = RW + 1;

  logic [CFG_W-1:0] image_width;
  logic [CFG_W-1:0] image_height;
  logic [XW-1:0]    w_lim;
  logic [YW-1:0]    h_lim;

  logic [CW-1:0]    col;
  logic [RW-1:0]    row;
  logic             a_first_col, a_last_col, a_first_row, a_last_row;
  logic             in_fire;

  logic             b_valid;
  logic             b_land;
  logic [CW-1:0]    b_col;
  logic             b_first_col, b_last_col, b_first_row, b_last_row;
  logic             b_fwd;
  cell_t            b_fwd_data;

  cell_t            left_pixel;
  logic [COUNT_W-1:0] run_count;
  logic [COUNT_W-1:0] count_next;
  logic [COUNT_W:0]   count_sum;
  logic [1:0]         inc;
  cell_t            above, left_w, cur;
  logic             flag;

  logic             pend_valid;
  logic [CW-1:0]    pend_addr;
  cell_t            pend_data;
  logic             wr_left, wr_last_direct, pend_set, pend_flush;

  logic             ram_we;
  logic [CW-1:0]    ram_waddr;
  cell_t            ram_wdata;
  cell_t            ram_rdata;

  result_t          out_q [OUT_DEPTH];
  logic [OUT_PTR_W-1:0] out_wp, out_rp;
  logic [OUT_CNT_W-1:0] out_cnt;
  logic             out_push, out_pop;
  result_t          out_item;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= DIM_RESET;
      image_height <= DIM_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:  image_width  <= cfg_data;
        REG_IMAGE_HEIGHT: image_height <= cfg_data;
      endcase
    end
  end

  always_comb begin
    if (image_width == '0) begin
      w_lim = XW'(1);
    end else if (32'(image_width) > MAX_WIDTH) begin
      w_lim = XW'(MAX_WIDTH);
    end else begin
      w_lim = XW'(image_width);
    end
    if (image_height == '0) begin
      h_lim = YW'(1);
    end else if (32'(image_height) > MAX_HEIGHT) begin
      h_lim = YW'(MAX_HEIGHT);
    end else begin
      h_lim = YW'(image_height);
    end
  end

  // accept stage
  assign a_first_col = (col == '0);
  assign a_first_row = (row == '0);
  assign a_last_col  = ((XW'(col) + XW'(1)) >= w_lim);
  assign a_last_row  = ((YW'(row) + YW'(1)) >= h_lim);

  assign pixel_in.ready = !rst &&
                          ((out_cnt + OUT_CNT_W'(b_valid)) < OUT_CNT_W'(OUT_DEPTH));
  assign in_fire = pixel_in.valid && pixel_in.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (in_fire) begin
      if (a_last_col) begin
        col <= '0;
        row <= a_last_row ? '0 : row + RW'(1);
      end else begin
        col <= col + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else begin
      b_valid <= in_fire;
    end
  end

  always_ff @(posedge clk) begin
    b_land      <= pixel_in.is_land;
    b_col       <= col;
    b_first_col <= a_first_col;
    b_last_col  <= a_last_col;
    b_first_row <= a_first_row;
    b_last_row  <= a_last_row;
    b_fwd       <= ram_we && (ram_waddr == col);
    b_fwd_data  <= ram_wdata;
  end

  // decide stage
  always_comb begin
    above = b_fwd ? b_fwd_data : ram_rdata;
    left_w = left_pixel;
    left_w.boundary = left_pixel.boundary | ~b_land;
    flag = b_first_row | b_last_row | b_first_col | b_last_col;
    inc = 2'd0;
    if (!b_first_col && !left_w.land) begin
      flag = 1'b1;
    end
    if (!b_first_row) begin
      if (above.land && (above.boundary || !b_land)) begin
        inc = inc + 2'd1;
      end
      if (!above.land) begin
        flag = 1'b1;
      end
    end
    if (b_last_row && b_land) begin
      inc = inc + 2'd1;
    end
    cur.boundary = flag;
    cur.land     = b_land;
    count_sum = {1'b0, run_count} + (COUNT_W + 1)'(inc);
    count_next = (count_sum > {1'b0, COUNT_MAX}) ? COUNT_MAX : count_sum[COUNT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      left_pixel <= '0;
      run_count  <= '0;
    end else if (b_valid) begin
      left_pixel <= b_last_col ? '0 : cur;
      run_count  <= (b_last_row && b_last_col) ? '0 : count_next;
    end
  end

  // line store writes: the row's last entry waits in a pending register for a free port
  assign wr_left        = b_valid && !b_first_col;
  assign wr_last_direct = b_valid && b_last_col && b_first_col;
  assign pend_set       = b_valid && b_last_col && !b_first_col;
  assign pend_flush     = pend_valid && !wr_left && !wr_last_direct;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = pend_addr;
    ram_wdata = pend_data;
    priority if (wr_left) begin
      ram_we    = 1'b1;
      ram_waddr = b_col - CW'(1);
      ram_wdata = left_w;
    end else if (wr_last_direct) begin
      ram_we    = 1'b1;
      ram_waddr = b_col;
      ram_wdata = cur;
    end else if (pend_valid) begin
      ram_we    = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (pend_set) begin
      pend_valid <= 1'b1;
    end else if (pend_flush) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pend_set) begin
      pend_addr <= b_col;
      pend_data <= cur;
    end
  end

  bibpc_line_ram #(
    .DEPTH (MAX_WIDTH),
    .AW    (CW)
  ) u_line_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (col),
    .rdata (ram_rdata)
  );

  // output queue
  assign out_push = b_valid;
  assign out_pop  = result_out.valid && result_out.ready;
  assign out_item.boundary_count = count_next;
  assign out_item.frame_done     = b_last_row && b_last_col;

  always_ff @(posedge clk) begin
    if (out_push) begin
      out_q[out_wp] <= out_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_wp  <= '0;
      out_rp  <= '0;
      out_cnt <= '0;
    end else begin
      if (out_push) begin
        out_wp <= out_wp + OUT_PTR_W'(1);
      end
      if (out_pop) begin
        out_rp <= out_rp + OUT_PTR_W'(1);
      end
      out_cnt <= out_cnt + OUT_CNT_W'(out_push) - OUT_CNT_W'(out_pop);
    end
  end

  assign result_out.valid          = (out_cnt != '0);
  assign result_out.boundary_count = out_q[out_rp].boundary_count;
  assign result_out.frame_done     = out_q[out_rp].frame_done;

  `BIBPC_ASSERT_NEVER(a_out_overflow, out_push && !out_pop && (out_cnt == OUT_CNT_W'(OUT_DEPTH)), "output queue overflow")
  `BIBPC_ASSERT(a_count_restart, b_valid && b_last_row && b_last_col |=> run_count == '0, "count not cleared after frame end")
  `BIBPC_ASSERT(a_left_clear, b_valid && b_first_col |-> left_pixel == '0, "left pixel not cleared at row start")

endmodule
